/* hw/rtl/def_pkg.sv */
// Shared types, constants and the per-channel emboss function for the
// diagonal emboss filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package def_pkg;

  localparam int CFG_W  = 12;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int PIX_W       = 32;
  localparam int RGB_W       = 24;
  localparam int POS_W       = 11;
  localparam int OUT_TDATA_W = 56;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [9:0] EMB_BIAS     = 10'd128;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] pixel;
  } res_t;

  // p - n + 128, clamped to 0..255
  function automatic logic [7:0] emboss_ch(input logic [7:0] p, input logic [7:0] n);
    logic [9:0] s;
    s = {2'b00, p} + EMB_BIAS - {2'b00, n};
    if (s[9]) begin
      emboss_ch = 8'h00;
    end else if (s[8]) begin
      emboss_ch = 8'hFF;
    end else begin
      emboss_ch = s[7:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/def_front.sv */
// Front end: position counters, config registers, line store and emboss math.
// Depends on def_pkg.
`timescale 1ns / 1ps
`default_nettype none

module def_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [def_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire  [def_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire                          in_take,
  input  wire  [def_pkg::RGB_W-1:0]    in_pix,
  input  wire                          in_first,
  output logic                         stage_busy,
  output logic                         push,
  output def_pkg::res_t                push_data
);
  import def_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic [WW-1:0]    width_r;
  logic [HW-1:0]    height_r;
  logic [XW-1:0]    col_r, col_nxt;
  logic [YW-1:0]    row_r, row_nxt;
  logic [RGB_W-1:0] line_mem [MAX_WIDTH];
  logic [RGB_W-1:0] above_r;
  logic [RGB_W-1:0] above_left_r;

  logic             s_vld_r, s_wr_r, s_emit_r, s_done_r;
  logic [RGB_W-1:0] s_pix_r;
  logic [POS_W-1:0] s_row_r, s_col_r;

  logic [WW-1:0]    w_sat;
  logic [HW-1:0]    h_sat;
  logic [XW-1:0]    x0;
  logic [YW-1:0]    y0;
  logic [WW-1:0]    x_ext, x_inc;
  logic [HW-1:0]    y_ext, y_inc;
  logic [XW-1:0]    xm1;
  logic [YW-1:0]    ym1;
  logic             in_range, y_in, x_last, y_last, emit, done;

  // saturate written dimensions to 2..MAX
  always_comb begin
    if (cfg_wdata < CFG_W'(2)) begin
      w_sat = WW'(2);
    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(cfg_wdata);
    end
    if (cfg_wdata < CFG_W'(2)) begin
      h_sat = HW'(2);
    end else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  width_r  <= w_sat;
        REG_FRAME_HEIGHT: height_r <= h_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    x0       = in_first ? '0 : col_r;
    y0       = in_first ? '0 : row_r;
    x_ext    = WW'(x0);
    y_ext    = HW'(y0);
    x_inc    = x_ext + WW'(1);
    y_inc    = y_ext + HW'(1);
    in_range = x_ext < width_r;
    y_in     = y_ext < height_r;
    x_last   = x_inc >= width_r;
    y_last   = y_inc >= height_r;
    emit     = in_range && y_in && (x0 != '0) && (y0 != '0);
    done     = (y_inc == height_r) && (x_inc == width_r);
    xm1      = x0 - XW'(1);
    ym1      = y0 - YW'(1);
    col_nxt  = x_last ? '0 : XW'(x_inc);
    row_nxt  = x_last ? (y_last ? '0 : YW'(y_inc)) : y0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: read-before-write at the same column
  always_ff @(posedge clk) begin
    if (in_take && in_range) begin
      line_mem[x0] <= in_pix;
      above_r      <= line_mem[x0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_wr_r   <= in_range;
      s_emit_r <= emit;
      s_done_r <= done;
      s_pix_r  <= in_pix;
      s_row_r  <= POS_W'(ym1);
      s_col_r  <= POS_W'(xm1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_left_r <= '0;
    end else if (s_vld_r && s_wr_r) begin
      above_left_r <= above_r;
    end
  end

  always_comb begin
    stage_busy      = s_vld_r;
    push            = s_vld_r && s_emit_r;
    push_data.pixel = {ALPHA_OPAQUE,
                       emboss_ch(above_left_r[23:16], s_pix_r[23:16]),
                       emboss_ch(above_left_r[15:8],  s_pix_r[15:8]),
                       emboss_ch(above_left_r[7:0],   s_pix_r[7:0])};
    push_data.row   = s_row_r;
    push_data.col   = s_col_r;
    push_data.done  = s_done_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/def_fifo.sv */
// Short result queue between front and back end.
// Depends on def_pkg.
`timescale 1ns / 1ps
`default_nettype none

module def_fifo (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  def_pkg::res_t              push_data,
  input  wire                        pop,
  output def_pkg::res_t              pop_data,
  output logic                       not_empty,
  output logic [def_pkg::QCW-1:0]    count
);
  import def_pkg::*;

  res_t           q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCW'(1);
        2'b01:   count_r <= count_r - QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign pop_data  = q_mem[rd_ptr_r];
  assign not_empty = count_r != '0;
  assign count     = count_r;

endmodule

`default_nettype wire

/* hw/rtl/def_back.sv */
// Back end: output register feeding the result stream.
// Depends on def_pkg.
`timescale 1ns / 1ps
`default_nettype none

module def_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_not_empty,
  input  def_pkg::res_t                    q_data,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [def_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import def_pkg::*;

  logic out_vld_r;
  res_t out_r;

  assign q_pop = q_not_empty && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (q_pop) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= q_data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r.col, out_r.row, out_r.pixel};
  assign out_tlast  = out_r.done;

endmodule

`default_nettype wire

/* hw/rtl/diagonal_emboss_filter_unit.sv */
// Diagonal emboss filter over a raster ARGB pixel stream.
// Input stream: in_tdata = ARGB pixel (alpha ignored), in_tuser = first pixel of frame.
// Output stream: out_tdata order pixel_out, row, column; out_tlast marks the
//   last result of the frame (row height-2, column width-2).
// Each result is pixel (y-1,x-1) minus pixel (y,x) plus 128 per color,
//   clamped to 0..255, alpha 0xFF; it leaves when pixel (y,x) is taken.
//   Last row and last column give no result.
// Config: cfg_we writes frame_width (index 0) or frame_height (index 1),
//   saturated to 2..MAX; write only while the stream is idle.
// Throughput: one pixel per clock while in_tready is high. Each result passes
//   the line-store stage, queue and output registers before reaching out_tvalid.
// Reset clears counters, queue and output; dimensions return to 640 x 480, capped at MAX.
//   The line store is not cleared; it is written one row before it is read.
// Receiver stall: results gather in a 4-entry queue; in_tready drops when
//   the queue plus the item in the line-store stage would fill it.
// Depends on def_pkg, def_front, def_fifo, def_back.
`timescale 1ns / 1ps
`default_nettype none

module diagonal_emboss_filter_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [def_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire  [def_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [def_pkg::PIX_W-1:0]        in_tdata,   // [31:0] pixel_in
  input  wire                              in_tuser,   // [0] frame_start
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [def_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [31:0] pixel_out, [42:32] out_row,
                                                       // [53:43] out_col, [55:54] zero
  output logic                             out_tlast   // frame_done
);
  import def_pkg::*;

  logic           in_take, stage_busy, push, pop, q_not_empty;
  logic [QCW-1:0] q_count;
  res_t           push_data, pop_data;

  assign in_tready = (q_count + QCW'(stage_busy)) < QCW'(QDEPTH);
  assign in_take   = in_tvalid && in_tready;

  def_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_take    (in_take),
    .in_pix     (in_tdata[RGB_W-1:0]),
    .in_first   (in_tuser),
    .stage_busy (stage_busy),
    .push       (push),
    .push_data  (push_data)
  );

  def_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  def_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

/* hw/rtl/def_checker.sv */
// Port-level checks on the emboss filter, bound to the top level.
// Depends on def_pkg and diagonal_emboss_filter_unit.
`timescale 1ns / 1ps
`default_nettype none

module def_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [def_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire                              out_tlast
);
  import def_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_alpha_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:24] == ALPHA_OPAQUE && out_tdata[55:54] == 2'b00)
    else $error("bad alpha or pad bits in output word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind diagonal_emboss_filter_unit def_checker u_def_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* verif/tb_top.sv */
// tb_top: self-checking testbench for diagonal_emboss_filter_unit. Drives ARGB frames
// with random gaps and receiver stalls, and checks every output word against an
// in-bench emboss predictor. Depends on def_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;
  import def_pkg::*;

  localparam int MAX_DIM    = 2048;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYC = 8;
  localparam int RAND_ITEMS = 750;

  class emboss_scoreboard;
    logic [RGB_W-1:0] prev_row [MAX_DIM];
    logic [RGB_W-1:0] upper_left;
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    res_t             expected_q [$];
    int unsigned      fail_count;

    function new();
      foreach (prev_row[i]) prev_row[i] = '0;
      upper_left = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      width_reg  = 12'd640;
      height_reg = 12'd480;
      fail_count = 0;
    endfunction

    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v < 2) return 2;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] v);
      if (addr == REG_FRAME_WIDTH) begin
        width_reg = v;
      end else begin
        height_reg = v;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // emboss of pixel (y-1,x-1) against (y,x), emitted as (y,x) is taken
    function void note_pixel(logic [PIX_W-1:0] word, logic first_px);
      logic [RGB_W-1:0] rgb;
      logic [RGB_W-1:0] above;
      res_t             r;
      int unsigned      w, h, y, x;
      int               a, b, d;
      w   = eff_dim(width_reg);
      h   = eff_dim(height_reg);
      rgb = word[RGB_W-1:0];
      if (first_px) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      y = row_cnt;
      x = col_cnt;
      if (x < w) begin
        above       = prev_row[x];
        prev_row[x] = rgb;
        if (y >= 1 && x >= 1 && y < h) begin
          r.pixel[31:24] = 8'hFF;
          for (int k = 0; k < 3; k++) begin
            a = upper_left[8*k +: 8];
            b = rgb[8*k +: 8];
            d = a - b + 128;
            if (d > 255) d = 255;
            if (d < 0) d = 0;
            r.pixel[8*k +: 8] = d[7:0];
          end
          r.row  = POS_W'(y - 1);
          r.col  = POS_W'(x - 1);
          r.done = (y == h - 1) && (x == w - 1);
          expected_q.push_back(r);
        end
        upper_left = above;
      end
      if (x + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col_cnt = x + 1;
      end
    endfunction

    function void log_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t ns: %s", $time, what);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word, logic last);
      logic [1:0]       pad;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] pix;
      res_t             exp_r;
      {pad, col, row, pix} = word;
      if (expected_q.size() == 0) begin
        log_failure($sformatf("unexpected word pixel %08h row %0d col %0d last %0b",
                              pix, row, col, last));
        return;
      end
      exp_r = expected_q.pop_front();
      if (pix !== exp_r.pixel || row !== exp_r.row || col !== exp_r.col ||
          last !== exp_r.done || pad !== 2'b00) begin
        log_failure($sformatf(
          "exp pixel %08h row %0d col %0d last %0b, got pixel %08h row %0d col %0d last %0b pad %0b",
          exp_r.pixel, exp_r.row, exp_r.col, exp_r.done, pix, row, col, last, pad));
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr  = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  emboss_scoreboard sb = new();
  bit               back_to_back;
  int unsigned      sent_px;
  int unsigned      filled_w;  // line store columns known to hold pixel data

  diagonal_emboss_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  initial begin
    int unsigned idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // receiver: ready bursts, mostly short stalls, now and then a long one
  initial begin
    int unsigned hi, lo, r;
    while (!rst_n) @(posedge clk);
    forever begin
      r  = $urandom_range(0, 99);
      hi = (r < 10) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (hi) @(posedge clk);
      r  = $urandom_range(0, 99);
      lo = (r < 25) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (lo != 0) begin
        out_tready <= 1'b0;
        repeat (lo) @(posedge clk);
      end
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: p[8*k +: 8] = 8'h00;
        1: p[8*k +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first_px);
    int unsigned gap, r;
    gap = 0;
    if (!back_to_back) begin
      r   = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= first_px;
    do @(posedge clk); while (!in_tready);
    sent_px++;
  endtask

  // drain all pending words, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FRAME_WIDTH;
    cfg_wdata <= w_val;
    @(posedge clk);
    cfg_addr  <= REG_FRAME_HEIGHT;
    cfg_wdata <= h_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(REG_FRAME_WIDTH, w_val);
    sb.set_reg(REG_FRAME_HEIGHT, h_val);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                           input int unsigned n_frames);
    int unsigned w, h, frames, len, cap;
    logic        fs;
    set_dims(w_val, h_val);
    w = sb.eff_dim(w_val);
    h = sb.eff_dim(h_val);
    back_to_back = ($urandom_range(0, 3) == 0);
    // counters may sit outside the new frame; stored columns are all valid here
    if (w <= filled_w && $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 4)) send_pixel(rand_pixel(), 1'b0);
    end
    frames = (n_frames != 0) ? n_frames : $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      len = w * h;
      if (len > 400) begin
        cap = $urandom_range(2 * w, 2 * w + 40);
        if (cap < len) len = cap;
      end else if ($urandom_range(0, 6) == 0) begin
        len = $urandom_range(w, len - 1);
      end
      fs = (f == 0) || ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) send_pixel(rand_pixel(), fs && (k == 0));
    end
    if (w > filled_w) filled_w = w;
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 12)) send_pixel(rand_pixel(), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [PIX_W-1:0] seed_px [17];
    logic [CFG_W-1:0] w_val, h_val;
    int unsigned      r, rand_base;
    seed_px = '{
      32'h00FFFFFF, 32'h5A123456, 32'hA5654321, 32'hFF000000,
      32'hFF000000, 32'h3C0F0F0F, 32'hC3F0F0F0, 32'hFFFFFFFF,
      32'h00FF7F80, 32'h11807F00, 32'h22000000,
      32'h33102030, 32'h44000001, 32'h55FFFFFF,
      32'h66AABBCC, 32'h77808080, 32'h88FF0000
    };
    sent_px  = 0;
    filled_w = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 frames from saturated registers: high clamp, then low clamp on a wrap
    back_to_back = 1'b1;
    set_dims(12'd0, 12'd1);
    for (int i = 0; i < 8; i++) send_pixel(seed_px[i], i == 0);
    filled_w = 2;

    // 3x3 frame with exact clamp edges, then leave the counters mid-row
    back_to_back = 1'b0;
    set_dims(12'd3, 12'd3);
    for (int i = 8; i < 17; i++) send_pixel(seed_px[i], i == 8);
    send_pixel(32'h9901FE7F, 1'b0);
    send_pixel(32'hAA7F01FE, 1'b0);
    filled_w = 3;

    // shrink the width: the next word lies beyond the frame
    set_dims(12'd2, 12'd2);
    send_pixel(32'hBB808080, 1'b0);
    send_pixel(32'hCC000000, 1'b0);

    rand_base = sent_px;
    while (sent_px - rand_base < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) w_val = $urandom_range(0, 1);
      else if (r < 80) w_val = $urandom_range(2, 9);
      else w_val = $urandom_range(10, 40);
      r = $urandom_range(0, 99);
      if (r < 8) h_val = $urandom_range(0, 1);
      else if (r < 12) h_val = $urandom_range(2048, 4095);
      else h_val = $urandom_range(2, 6);
      run_phase(w_val, h_val, 0);
    end

    settle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/def_pkg.sv
hw/rtl/def_front.sv
hw/rtl/def_fifo.sv
hw/rtl/def_back.sv
hw/rtl/diagonal_emboss_filter_unit.sv
hw/rtl/def_checker.sv
verif/tb_top.sv
